### rtl/tsa_pkg.sv
// Shared types, constants and decode functions for the tagged stack ALU.
package tsa_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int IDX_W       = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int DEPTH_W     = 7;
  localparam int VAL_W       = 64;
  localparam int TAG_W       = 2;
  localparam int ACT_W       = 6;
  localparam int ST_W        = 3;

  typedef enum logic [ST_W-1:0] {
    ST_OK    = 3'd0,
    ST_UNDER = 3'd1,
    ST_TYPE  = 3'd2,
    ST_DIVZ  = 3'd3,
    ST_OVER  = 3'd4
  } status_e;

  typedef enum logic [TAG_W-1:0] {
    TAG_INT  = 2'd0,
    TAG_BYTE = 2'd1,
    TAG_BOOL = 2'd2,
    TAG_CHAR = 2'd3
  } tag_e;

  typedef enum logic [4:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV, OP_MOD, OP_NEG, OP_INC, OP_DEC,
    OP_AND, OP_OR, OP_XOR, OP_NOT, OP_SHL, OP_SAR, OP_BSHL, OP_BSHR,
    OP_EQ, OP_NE, OP_LT, OP_LE, OP_GT, OP_GE, OP_PASS
  } alu_op_e;

  typedef enum logic [2:0] {
    K_PUSH, K_POP, K_DUP, K_SWAP, K_ALU, K_NOP
  } kind_e;

  // Instruction codes that open each group
  localparam logic [ACT_W-1:0] A_PUSH = 6'd0;
  localparam logic [ACT_W-1:0] A_POP  = 6'd1;
  localparam logic [ACT_W-1:0] A_DUP  = 6'd2;
  localparam logic [ACT_W-1:0] A_SWAP = 6'd3;
  localparam logic [ACT_W-1:0] A_IAR  = 6'd4;
  localparam logic [ACT_W-1:0] A_BAR  = 6'd12;
  localparam logic [ACT_W-1:0] A_ICMP = 6'd20;
  localparam logic [ACT_W-1:0] A_BCMP = 6'd26;
  localparam logic [ACT_W-1:0] A_BOOL = 6'd32;
  localparam logic [ACT_W-1:0] A_IBIT = 6'd36;
  localparam logic [ACT_W-1:0] A_BBIT = 6'd42;
  localparam logic [ACT_W-1:0] A_CONV = 6'd48;

  // Individual instruction codes
  localparam logic [ACT_W-1:0] A_ISUB = 6'd5;
  localparam logic [ACT_W-1:0] A_IDIV = 6'd7;
  localparam logic [ACT_W-1:0] A_IMOD = 6'd8;
  localparam logic [ACT_W-1:0] A_INEG = 6'd9;
  localparam logic [ACT_W-1:0] A_BNEG = 6'd17;
  localparam logic [ACT_W-1:0] A_LNOT = 6'd34;
  localparam logic [ACT_W-1:0] A_INOT = 6'd39;
  localparam logic [ACT_W-1:0] A_BNOT = 6'd45;
  localparam logic [ACT_W-1:0] A_BSHL = 6'd46;
  localparam logic [ACT_W-1:0] A_B2I  = 6'd48;
  localparam logic [ACT_W-1:0] A_C2B  = 6'd49;
  localparam logic [ACT_W-1:0] A_B2C  = 6'd50;
  localparam logic [ACT_W-1:0] A_L2B  = 6'd51;
  localparam logic [ACT_W-1:0] A_LAST = 6'd51;

  typedef struct packed {
    tag_e              tag;
    logic [VAL_W-1:0]  value;
  } entry_t;

  typedef struct packed {
    kind_e   kind;
    alu_op_e op;
    logic    two;
    tag_e    tin;
    tag_e    tout;
  } dec_t;

  typedef struct packed {
    logic             start;
    alu_op_e          op;
    logic [VAL_W-1:0] a;
    logic [VAL_W-1:0] b;
  } alu_req_t;

  typedef struct packed {
    logic             done;
    logic [VAL_W-1:0] result;
  } alu_rsp_t;

  function automatic alu_op_e arith_op(logic [2:0] k);
    alu_op_e o;
    case (k)
      3'd0:    o = OP_ADD;
      3'd1:    o = OP_SUB;
      3'd2:    o = OP_MUL;
      3'd3:    o = OP_DIV;
      3'd4:    o = OP_MOD;
      3'd5:    o = OP_NEG;
      3'd6:    o = OP_INC;
      default: o = OP_DEC;
    endcase
    return o;
  endfunction

  function automatic alu_op_e cmp_op(logic [2:0] k);
    alu_op_e o;
    case (k)
      3'd0:    o = OP_EQ;
      3'd1:    o = OP_NE;
      3'd2:    o = OP_LT;
      3'd3:    o = OP_LE;
      3'd4:    o = OP_GT;
      default: o = OP_GE;
    endcase
    return o;
  endfunction

  function automatic alu_op_e bit_op(logic [2:0] k, logic is_byte);
    alu_op_e o;
    case (k)
      3'd0:    o = OP_AND;
      3'd1:    o = OP_OR;
      3'd2:    o = OP_XOR;
      3'd3:    o = OP_NOT;
      3'd4:    o = is_byte ? OP_BSHL : OP_SHL;
      default: o = is_byte ? OP_BSHR : OP_SAR;
    endcase
    return o;
  endfunction

  function automatic dec_t decode(logic [ACT_W-1:0] act);
    dec_t d;
    logic [1:0] c;
    d = '{kind: K_NOP, op: OP_PASS, two: 1'b0, tin: TAG_INT, tout: TAG_INT};
    c = act[1:0];
    unique case (act) inside
      A_PUSH: d.kind = K_PUSH;
      A_POP:  d.kind = K_POP;
      A_DUP:  d.kind = K_DUP;
      A_SWAP: d.kind = K_SWAP;
      [A_IAR:A_BAR-6'd1]: begin
        d.kind = K_ALU; d.op = arith_op(3'(act - A_IAR)); d.two = (act < A_INEG);
      end
      [A_BAR:A_ICMP-6'd1]: begin
        d.kind = K_ALU; d.op = arith_op(3'(act - A_BAR)); d.two = (act < A_BNEG);
        d.tin = TAG_BYTE; d.tout = TAG_BYTE;
      end
      [A_ICMP:A_BCMP-6'd1]: begin
        d.kind = K_ALU; d.op = cmp_op(3'(act - A_ICMP)); d.two = 1'b1;
        d.tout = TAG_BOOL;
      end
      [A_BCMP:A_BOOL-6'd1]: begin
        d.kind = K_ALU; d.op = cmp_op(3'(act - A_BCMP)); d.two = 1'b1;
        d.tin = TAG_BYTE; d.tout = TAG_BOOL;
      end
      [A_BOOL:A_IBIT-6'd1]: begin
        d.kind = K_ALU; d.tin = TAG_BOOL; d.tout = TAG_BOOL;
        d.two = (act != A_LNOT);
        case (c)
          2'd0:    d.op = OP_AND;
          2'd1:    d.op = OP_OR;
          2'd2:    d.op = OP_NOT;
          default: d.op = OP_XOR;
        endcase
      end
      [A_IBIT:A_BBIT-6'd1]: begin
        d.kind = K_ALU; d.op = bit_op(3'(act - A_IBIT), 1'b0); d.two = (act != A_INOT);
      end
      [A_BBIT:A_CONV-6'd1]: begin
        d.kind = K_ALU; d.op = bit_op(3'(act - A_BBIT), 1'b1); d.two = (act != A_BNOT);
        d.tin = TAG_BYTE; d.tout = TAG_BYTE;
      end
      [A_CONV:A_LAST]: begin
        d.kind = K_ALU; d.op = OP_PASS;
        case (2'(act - A_CONV))
          2'd0:    begin d.tin = TAG_BYTE; d.tout = TAG_INT;  end
          2'd1:    begin d.tin = TAG_CHAR; d.tout = TAG_BYTE; end
          2'd2:    begin d.tin = TAG_BYTE; d.tout = TAG_CHAR; end
          default: begin d.tin = TAG_BOOL; d.tout = TAG_BYTE; end
        endcase
      end
      default: d.kind = K_NOP;
    endcase
    return d;
  endfunction

  // Trim a value to the range of its type
  function automatic logic [VAL_W-1:0] mask_val(tag_e t, logic [VAL_W-1:0] v);
    logic [VAL_W-1:0] r;
    case (t)
      TAG_BYTE, TAG_CHAR: r = {{(VAL_W-8){1'b0}}, v[7:0]};
      TAG_BOOL:           r = {{(VAL_W-1){1'b0}}, v[0]};
      default:            r = v;
    endcase
    return r;
  endfunction

endpackage

### rtl/tagged_stack_alu.sv
// Top level: instruction sequencer around the operand stack and the shared ALU.
//
//  channel | dir | handshake                        | payload
//  --------+-----+----------------------------------+----------------------------------
//  s_axis  | in  | s_axis_tvalid_i / s_axis_tready_o | tdata: action, imm_value; tuser: imm_tag
//  m_axis  | out | m_axis_tvalid_o / m_axis_tready_i | tdata: status, top_value, top_valid,
//          |     |                                  |   depth; tuser: top_tag
//
// One request at a time. Each is decoded in S_DEC; push, pop and dup then go to S_OUT,
// swap writes its second entry in S_WR2, and ALU ops wait in S_ALU for the shared unit;
// multiply and divide step through its adder. A divide by zero that uncovers an older
// entry reads the new top via S_RTOP and S_LTOP. Reset empties the stack at once, with
// no clearing pass. s_axis_tready_o stays low from accept until the result is taken.
module tagged_stack_alu (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [71:0] s_axis_tdata_i,   // [5:0] action, [69:6] imm_value, [71:70] zero
  input  logic [1:0]  s_axis_tuser_i,   // [1:0] imm_tag
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [79:0] m_axis_tdata_o,   // [2:0] status, [66:3] top_value, [67] top_valid,
                                        // [74:68] depth, [79:75] zero
  output logic [1:0]  m_axis_tuser_o    // [1:0] top_tag
);
  import tsa_pkg::*;

  typedef enum logic [7:0] {
    S_IDLE = 8'b00000001,
    S_DEC  = 8'b00000010,
    S_WR2  = 8'b00000100,
    S_ALU  = 8'b00001000,
    S_RTOP = 8'b00010000,
    S_LTOP = 8'b00100000,
    S_OUT  = 8'b01000000,
    S_SPR  = 8'b10000000
  } seq_state_e;

  seq_state_e         state_q, state_d;
  logic [CNT_W-1:0]   count_q, count_d;
  entry_t             top_q, top_d, opa_q, opa_d;
  status_e            status_q, status_d;
  logic [ACT_W-1:0]   act_q;
  logic [VAL_W-1:0]   imm_q;
  tag_e               itag_q;

  logic               in_acc;
  dec_t               dec;
  entry_t             sec, push_e, wdata;
  logic               we;
  logic [IDX_W-1:0]   waddr, raddr;
  logic [CNT_W-1:0]   cnt_m1, cnt_m2, cnt_pop;
  alu_req_t           alu_req;
  alu_rsp_t           alu_rsp;

  assign in_acc = s_axis_tvalid_i && s_axis_tready_o;
  assign dec    = decode(act_q);
  assign cnt_m1 = count_q - CNT_W'(1);
  assign cnt_m2 = count_q - CNT_W'(2);
  assign cnt_pop = dec.two ? cnt_m2 : cnt_m1;

  // Form the pushed immediate
  always_comb begin
    push_e.tag = itag_q;
    if (itag_q == TAG_BOOL) begin
      push_e.value = VAL_W'(imm_q != '0);
    end else begin
      push_e.value = mask_val(itag_q, imm_q);
    end
  end

  tsa_mem u_mem (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (sec)
  );

  tsa_alu u_alu (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (alu_req),
    .rsp_o  (alu_rsp)
  );

  // Sequence one instruction
  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    top_d         = top_q;
    opa_d         = opa_q;
    status_d      = status_q;
    we            = 1'b0;
    waddr         = count_q[IDX_W-1:0];
    wdata         = top_q;
    raddr         = cnt_m2[IDX_W-1:0];
    alu_req.start = 1'b0;
    alu_req.op    = dec.op;
    alu_req.a     = top_q.value;
    alu_req.b     = sec.value;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d  = S_DEC;
          status_d = ST_OK;
        end
      end
      S_DEC: begin
        state_d = S_OUT;
        unique case (dec.kind)
          K_PUSH: begin
            if (count_q == CNT_W'(STACK_DEPTH)) begin
              status_d = ST_OVER;
            end else begin
              we = 1'b1; wdata = push_e; top_d = push_e; count_d = count_q + CNT_W'(1);
            end
          end
          K_POP: begin
            if (count_q == '0) begin
              status_d = ST_UNDER;
            end else begin
              count_d = cnt_m1; top_d = sec;
            end
          end
          K_DUP: begin
            if (count_q == '0) begin
              status_d = ST_UNDER;
            end else if (count_q == CNT_W'(STACK_DEPTH)) begin
              status_d = ST_OVER;
            end else begin
              we = 1'b1; count_d = count_q + CNT_W'(1);
            end
          end
          K_SWAP: begin
            if (count_q < CNT_W'(2)) begin
              status_d = ST_UNDER;
            end else begin
              we = 1'b1; waddr = cnt_m1[IDX_W-1:0]; wdata = sec;
              top_d = sec; opa_d = top_q; state_d = S_WR2;
            end
          end
          K_ALU: begin
            if (count_q == '0) begin
              status_d = ST_UNDER;
            end else if (top_q.tag != dec.tin) begin
              status_d = ST_TYPE;
            end else if (dec.two && count_q < CNT_W'(2)) begin
              status_d = ST_UNDER;
            end else if (dec.two && sec.tag != dec.tin) begin
              status_d = ST_TYPE;
            end else if ((dec.op == OP_DIV || dec.op == OP_MOD) && sec.value == '0) begin
              status_d = ST_DIVZ;
              count_d  = cnt_m2;
              if (cnt_m2 != '0) state_d = S_RTOP;
            end else begin
              alu_req.start = 1'b1;
              state_d       = S_ALU;
            end
          end
          default: ;
        endcase
      end
      S_WR2: begin
        we = 1'b1; waddr = cnt_m2[IDX_W-1:0]; wdata = opa_q; state_d = S_OUT;
      end
      S_ALU: begin
        if (alu_rsp.done) begin
          wdata.tag   = dec.tout;
          wdata.value = mask_val(dec.tout, alu_rsp.result);
          we          = 1'b1;
          waddr       = cnt_pop[IDX_W-1:0];
          top_d       = wdata;
          count_d     = cnt_pop + CNT_W'(1);
          state_d     = S_OUT;
        end
      end
      S_RTOP: begin
        raddr   = cnt_m1[IDX_W-1:0];
        state_d = S_LTOP;
      end
      S_LTOP: begin
        top_d   = sec;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (m_axis_tready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Hold request fields, top cache and status
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q  <= s_axis_tdata_i[ACT_W-1:0];
      imm_q  <= s_axis_tdata_i[ACT_W+VAL_W-1:ACT_W];
      itag_q <= tag_e'(s_axis_tuser_i);
    end
    top_q    <= top_d;
    opa_q    <= opa_d;
    status_q <= status_d;
  end

  // Drive the ports
  logic              nonempty;
  logic [VAL_W-1:0]  top_val;
  assign nonempty        = (count_q != '0);
  assign top_val         = nonempty ? top_q.value : '0;
  assign s_axis_tready_o = (state_q == S_IDLE);
  assign m_axis_tvalid_o = (state_q == S_OUT);
  assign m_axis_tdata_o  = {5'b0, DEPTH_W'(count_q), nonempty, top_val, status_q};
  assign m_axis_tuser_o  = nonempty ? top_q.tag : TAG_INT;
endmodule

### rtl/tsa_mem.sv
// Operand stack storage: one write port, one registered read port.
module tsa_mem (
  input  logic                      clk_i,
  input  logic                      we_i,
  input  logic [tsa_pkg::IDX_W-1:0] waddr_i,
  input  tsa_pkg::entry_t           wdata_i,
  input  logic [tsa_pkg::IDX_W-1:0] raddr_i,
  output tsa_pkg::entry_t           rdata_o
);
  import tsa_pkg::*;

  entry_t mem_q [STACK_DEPTH];
  entry_t rdata_q;

  // Write entry
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Read entry
  always_ff @(posedge clk_i) begin
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

### rtl/tsa_alu.sv
// Shared 65-bit adder with sequencer for simple ops, shift-add multiply, restoring divide.
module tsa_alu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  tsa_pkg::alu_req_t req_i,
  output tsa_pkg::alu_rsp_t rsp_o
);
  import tsa_pkg::*;

  typedef enum logic [6:0] {
    U_IDLE = 7'b0000001,
    U_MUL  = 7'b0000010,
    U_ABSA = 7'b0000100,
    U_ABSB = 7'b0001000,
    U_DIV  = 7'b0010000,
    U_FIX  = 7'b0100000,
    U_DONE = 7'b1000000
  } alu_state_e;

  alu_state_e       state_q, state_d;
  alu_op_e          op_q;
  logic [VAL_W-1:0] x_q, y_q, acc_q, res_q;
  logic             na_q, nb_q;
  logic [5:0]       cnt_q;

  logic [VAL_W:0]   add_x, add_y, add_sum;
  logic             add_sub;
  logic [VAL_W-1:0] rem_sh, fix_sel, simple;
  logic             fix_neg, borrow, lt, eq;

  assign rem_sh  = {acc_q[VAL_W-2:0], x_q[VAL_W-1]};
  assign fix_sel = (op_q == OP_MOD) ? acc_q : x_q;
  assign fix_neg = (op_q == OP_MOD) ? na_q : (na_q ^ nb_q);

  // Steer the shared adder
  always_comb begin
    add_x   = {req_i.a[VAL_W-1], req_i.a};
    add_y   = {req_i.b[VAL_W-1], req_i.b};
    add_sub = 1'b1;
    unique case (state_q)
      U_MUL: begin
        add_x = {1'b0, acc_q}; add_y = {1'b0, x_q}; add_sub = 1'b0;
      end
      U_ABSA: begin add_x = '0; add_y = {1'b0, x_q}; end
      U_ABSB: begin add_x = '0; add_y = {1'b0, y_q}; end
      U_DIV:  begin add_x = {1'b0, rem_sh}; add_y = {1'b0, y_q}; end
      U_FIX:  begin add_x = '0; add_y = {1'b0, fix_sel}; end
      default: begin
        case (req_i.op)
          OP_ADD: add_sub = 1'b0;
          OP_NEG: begin add_x = '0; add_y = {req_i.a[VAL_W-1], req_i.a}; end
          OP_INC: begin add_y = (VAL_W+1)'(1); add_sub = 1'b0; end
          OP_DEC: add_y = (VAL_W+1)'(1);
          default: ;
        endcase
      end
    endcase
    add_sum = add_x + (add_sub ? ~add_y : add_y) + (VAL_W+1)'(add_sub);
  end

  assign borrow = add_sum[VAL_W];
  assign lt     = add_sum[VAL_W];
  assign eq     = (req_i.a == req_i.b);

  // Combinational results of the simple ops
  always_comb begin
    case (req_i.op)
      OP_ADD, OP_SUB, OP_NEG, OP_INC, OP_DEC: simple = add_sum[VAL_W-1:0];
      OP_AND:  simple = req_i.a & req_i.b;
      OP_OR:   simple = req_i.a | req_i.b;
      OP_XOR:  simple = req_i.a ^ req_i.b;
      OP_NOT:  simple = ~req_i.a;
      OP_SHL:  simple = req_i.a << req_i.b[5:0];
      OP_SAR:  simple = VAL_W'($signed(req_i.a) >>> req_i.b[5:0]);
      OP_BSHL: simple = (req_i.b >= VAL_W'(8)) ? '0 : (req_i.a << req_i.b[2:0]);
      OP_BSHR: simple = (req_i.b >= VAL_W'(8)) ? '0 : (req_i.a >> req_i.b[2:0]);
      OP_EQ:   simple = VAL_W'(eq);
      OP_NE:   simple = VAL_W'(!eq);
      OP_LT:   simple = VAL_W'(lt);
      OP_LE:   simple = VAL_W'(lt || eq);
      OP_GT:   simple = VAL_W'(!lt && !eq);
      OP_GE:   simple = VAL_W'(!lt);
      default: simple = req_i.a;
    endcase
  end

  // Sequence the unit
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      U_IDLE: begin
        if (req_i.start) begin
          if (req_i.op == OP_MUL) begin
            state_d = U_MUL;
          end else if (req_i.op == OP_DIV || req_i.op == OP_MOD) begin
            state_d = U_ABSA;
          end else begin
            state_d = U_DONE;
          end
        end
      end
      U_MUL:   if (cnt_q == 6'd63) state_d = U_DONE;
      U_ABSA:  state_d = U_ABSB;
      U_ABSB:  state_d = U_DIV;
      U_DIV:   if (cnt_q == 6'd63) state_d = U_FIX;
      U_FIX:   state_d = U_DONE;
      U_DONE:  state_d = U_IDLE;
      default: state_d = U_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= U_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Advance operands, accumulator and counter
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      U_IDLE: begin
        op_q  <= req_i.op;
        x_q   <= req_i.a;
        y_q   <= req_i.b;
        na_q  <= req_i.a[VAL_W-1];
        nb_q  <= req_i.b[VAL_W-1];
        acc_q <= '0;
        cnt_q <= '0;
        res_q <= simple;
      end
      U_MUL: begin
        if (y_q[0]) acc_q <= add_sum[VAL_W-1:0];
        x_q   <= x_q << 1;
        y_q   <= y_q >> 1;
        cnt_q <= cnt_q + 6'd1;
        res_q <= y_q[0] ? add_sum[VAL_W-1:0] : acc_q;
      end
      U_ABSA: if (na_q) x_q <= add_sum[VAL_W-1:0];
      U_ABSB: if (nb_q) y_q <= add_sum[VAL_W-1:0];
      U_DIV: begin
        acc_q <= borrow ? rem_sh : add_sum[VAL_W-1:0];
        x_q   <= {x_q[VAL_W-2:0], ~borrow};
        cnt_q <= cnt_q + 6'd1;
      end
      U_FIX:   res_q <= fix_neg ? add_sum[VAL_W-1:0] : fix_sel;
      default: ;
    endcase
  end

  assign rsp_o.done   = (state_q == U_DONE);
  assign rsp_o.result = res_q;
endmodule

### rtl/tsa_checker.sv
// Port-level checks for the tagged stack ALU, bound to the top level.
module tsa_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid_i,
  input logic        s_axis_tready_o,
  input logic        m_axis_tvalid_o,
  input logic        m_axis_tready_i,
  input logic [79:0] m_axis_tdata_o,
  input logic [1:0]  m_axis_tuser_o
);
  import tsa_pkg::*;

  // Hold a stalled result
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // Take no request while a result waits
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready_o && m_axis_tvalid_o))
    else $error("request taken while result pending");

  // Keep depth within the stack
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> m_axis_tdata_o[74:68] <= 7'(STACK_DEPTH))
    else $error("depth beyond stack size");

  // Empty stack shows a zero top
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[74:68] == 7'd0 |->
      !m_axis_tdata_o[67] && m_axis_tdata_o[66:3] == '0 && m_axis_tuser_o == 2'd0)
    else $error("empty stack shows a top entry");

  // Accepted request blocks the input next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input ready right after accept");
endmodule

bind tagged_stack_alu tsa_checker u_tsa_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tvalid_i (s_axis_tvalid_i),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .m_axis_tuser_o  (m_axis_tuser_o)
);

### verif/tb_tagged_stack_alu.sv
// Self-checking testbench for the tagged stack ALU: random instruction streams against a predictor.
`timescale 1ns / 1ps

module tb_tagged_stack_alu;
  import tsa_pkg::*;

  localparam logic [ACT_W-1:0] A_UNUSED = 6'd63;

  typedef struct {
    status_e          status;
    logic [VAL_W-1:0] top_value;
    tag_e             top_tag;
    logic             top_valid;
    logic [6:0]       depth;
  } stack_view_t;

  // Predictor: holds its own copy of the stack and queues the expected views
  class stack_scoreboard;
    logic [VAL_W-1:0] vals[STACK_DEPTH];
    tag_e             tags[STACK_DEPTH];
    int               cnt;
    stack_view_t      pending[$];
    int               errors;
    int               checked;

    function automatic status_e push_slot(logic [VAL_W-1:0] v, tag_e t);
      if (cnt >= STACK_DEPTH) return ST_OVER;
      vals[cnt] = v;
      tags[cnt] = t;
      cnt++;
      return ST_OK;
    endfunction

    // Check and pop n operands of tag t; top goes to a
    function automatic status_e take(int n, tag_e t, output logic [VAL_W-1:0] a,
                                     output logic [VAL_W-1:0] b);
      a = '0;
      b = '0;
      if (cnt < 1) return ST_UNDER;
      if (tags[cnt-1] != t) return ST_TYPE;
      a = vals[cnt-1];
      if (n == 1) begin
        cnt--;
        return ST_OK;
      end
      if (cnt < 2) return ST_UNDER;
      if (tags[cnt-2] != t) return ST_TYPE;
      b = vals[cnt-2];
      cnt -= 2;
      return ST_OK;
    endfunction

    function automatic logic cmp(int k, logic [VAL_W-1:0] a, logic [VAL_W-1:0] b);
      case (k)
        0: return a == b;
        1: return a != b;
        2: return a < b;
        3: return a <= b;
        4: return a > b;
        default: return a >= b;
      endcase
    endfunction

    function automatic void note_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] imm,
                                         tag_e itag);
      status_e st;
      logic [VAL_W-1:0] a, b, r, ua, ub, q, m;
      tag_e rt;
      logic emit;
      stack_view_t e;
      int k;
      st = ST_OK;
      r = '0;
      rt = TAG_INT;
      emit = 1'b0;
      a = '0;
      b = '0;
      if (act == A_PUSH) begin
        r = imm;
        if (itag == TAG_BYTE || itag == TAG_CHAR) r = {56'd0, imm[7:0]};
        else if (itag == TAG_BOOL) r = 64'(imm != 0);
        st = push_slot(r, itag);
      end else if (act == A_POP) begin
        if (cnt < 1) st = ST_UNDER;
        else cnt--;
      end else if (act == A_DUP) begin
        if (cnt < 1) st = ST_UNDER;
        else st = push_slot(vals[cnt-1], tags[cnt-1]);
      end else if (act == A_SWAP) begin
        if (cnt < 2) st = ST_UNDER;
        else begin
          r = vals[cnt-1]; rt = tags[cnt-1];
          vals[cnt-1] = vals[cnt-2]; tags[cnt-1] = tags[cnt-2];
          vals[cnt-2] = r; tags[cnt-2] = rt;
        end
      end else if (act >= A_IAR && act < A_BAR) begin
        st = take(act < A_INEG ? 2 : 1, TAG_INT, a, b);
        if (st == ST_OK) begin
          emit = 1'b1;
          k = act - A_IAR;
          case (k)
            0: r = a + b;
            1: r = a - b;
            2: r = a * b;
            3, 4: begin
              if (b == 0) begin
                st = ST_DIVZ; emit = 1'b0;
              end else begin
                ua = a[63] ? -a : a;
                ub = b[63] ? -b : b;
                q = ua / ub; m = ua % ub;
                if (k == 4) r = a[63] ? -m : m;
                else r = (a[63] != b[63]) ? -q : q;
              end
            end
            5: r = -a;
            6: r = a + 1;
            default: r = a - 1;
          endcase
        end
      end else if (act >= A_BAR && act < A_ICMP) begin
        st = take(act < A_BNEG ? 2 : 1, TAG_BYTE, a, b);
        if (st == ST_OK) begin
          emit = 1'b1; rt = TAG_BYTE;
          k = act - A_BAR;
          case (k)
            0: r = a + b;
            1: r = a - b;
            2: r = a * b;
            3, 4: begin
              if (b == 0) begin
                st = ST_DIVZ; emit = 1'b0;
              end else r = (k == 3) ? a / b : a % b;
            end
            5: r = -a;
            6: r = a + 1;
            default: r = a - 1;
          endcase
          r &= 64'hFF;
        end
      end else if (act >= A_ICMP && act < A_BOOL) begin
        st = take(2, act < A_BCMP ? TAG_INT : TAG_BYTE, a, b);
        if (st == ST_OK) begin
          if (act < A_BCMP) begin
            a[63] = ~a[63]; b[63] = ~b[63];
          end
          r = 64'(cmp(act < A_BCMP ? act - A_ICMP : act - A_BCMP, a, b));
          rt = TAG_BOOL; emit = 1'b1;
        end
      end else if (act >= A_BOOL && act < A_IBIT) begin
        st = take(act == A_LNOT ? 1 : 2, TAG_BOOL, a, b);
        if (st == ST_OK) begin
          emit = 1'b1; rt = TAG_BOOL;
          case (act - A_BOOL)
            0: r = a & b;
            1: r = a | b;
            2: r = a ^ 1;
            default: r = a ^ b;
          endcase
          r &= 64'd1;
        end
      end else if (act >= A_IBIT && act < A_BBIT) begin
        st = take(act == A_INOT ? 1 : 2, TAG_INT, a, b);
        if (st == ST_OK) begin
          emit = 1'b1;
          case (act - A_IBIT)
            0: r = a & b;
            1: r = a | b;
            2: r = a ^ b;
            3: r = ~a;
            4: r = a << b[5:0];
            default: r = $signed(a) >>> b[5:0];
          endcase
        end
      end else if (act >= A_BBIT && act < A_CONV) begin
        st = take(act == A_BNOT ? 1 : 2, TAG_BYTE, a, b);
        if (st == ST_OK) begin
          emit = 1'b1; rt = TAG_BYTE;
          case (act - A_BBIT)
            0: r = a & b;
            1: r = a | b;
            2: r = a ^ b;
            3: r = ~a;
            4: r = (b >= 8) ? 0 : a << b;
            default: r = (b >= 8) ? 0 : a >> b;
          endcase
          r &= 64'hFF;
        end
      end else if (act >= A_CONV && act <= A_LAST) begin
        case (act - A_CONV)
          0: begin st = take(1, TAG_BYTE, a, b); rt = TAG_INT;  end
          1: begin st = take(1, TAG_CHAR, a, b); rt = TAG_BYTE; end
          2: begin st = take(1, TAG_BYTE, a, b); rt = TAG_CHAR; end
          default: begin st = take(1, TAG_BOOL, a, b); rt = TAG_BYTE; end
        endcase
        if (st == ST_OK) begin
          emit = 1'b1; r = a & 64'hFF;
        end
      end
      if (emit) st = push_slot(r, rt);
      e.status = st;
      e.top_valid = (cnt > 0);
      e.top_value = cnt > 0 ? vals[cnt-1] : '0;
      e.top_tag = cnt > 0 ? tags[cnt-1] : TAG_INT;
      e.depth = cnt[6:0];
      pending.insert(pending.size(), e);
    endfunction

    function automatic void check_result(logic [79:0] d, logic [1:0] u);
      stack_view_t e;
      checked++;
      if (pending.size() == 0) begin
        $display("%0t: unexpected result %h", $time, d);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (d[2:0] !== e.status || d[66:3] !== e.top_value || d[67] !== e.top_valid ||
          d[74:68] !== e.depth || u !== e.top_tag || d[79:75] !== 5'd0) begin
        $display("%0t: mismatch exp st=%0d val=%h vld=%0b dep=%0d tag=%0d", $time,
                 e.status, e.top_value, e.top_valid, e.depth, e.top_tag);
        $display("%0t:          got st=%0d val=%h vld=%0b dep=%0d tag=%0d", $time,
                 d[2:0], d[66:3], d[67], d[74:68], u);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [71:0] s_axis_tdata_i = '0;
  logic [1:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [79:0] m_axis_tdata_o;
  logic [1:0]  m_axis_tuser_o;

  stack_scoreboard sb = new();
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int sent = 0;

  tagged_stack_alu DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Receive side: random stall, check each accepted result
  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready_i <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      sb.check_result(m_axis_tdata_o, m_axis_tuser_o);
  end

  // Send one request; idle gaps before it, then hold until accepted
  task automatic send_request(logic [ACT_W-1:0] act, logic [VAL_W-1:0] imm, tag_e t);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i <= {2'b00, imm, act};
    s_axis_tuser_i <= t;
    @(posedge clk_i);
    while (!s_axis_tready_o) @(posedge clk_i);
    sb.note_request(act, imm, t);
    sent++;
    @(negedge clk_i);
  endtask

  function automatic logic [VAL_W-1:0] rand_value();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'($urandom_range(15));
      2: return -64'($urandom_range(15));
      3: return {1'b1, 63'd0};
      4: return 64'($urandom_range(300));
      default: return {1'b0, {63{1'b1}}};
    endcase
  endfunction

  function automatic tag_e tag_for(logic [ACT_W-1:0] act);
    if (act >= A_BOOL && act < A_IBIT) return TAG_BOOL;
    if ((act >= A_BAR && act < A_ICMP) || (act >= A_BCMP && act < A_BOOL) ||
        (act >= A_BBIT && act < A_CONV) || act == A_B2I || act == A_B2C) return TAG_BYTE;
    if (act == A_C2B) return TAG_CHAR;
    if (act == A_L2B) return TAG_BOOL;
    return TAG_INT;
  endfunction

  // Mostly well-formed sequence: push two operands, usually of the matching tag, then apply an op
  task automatic run_op(logic [ACT_W-1:0] act);
    tag_e t;
    t = tag_for(act);
    if ($urandom_range(9) == 0) t = tag_e'($urandom_range(3));
    send_request(A_PUSH, rand_value(), t);
    send_request(A_PUSH, rand_value(), t);
    send_request(act, rand_value(), tag_e'($urandom_range(3)));
  endtask

  initial begin
    int phase;
    int i;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: underflow on empty, extremes, every op, divide by zero, fill to overflow
    send_request(A_POP, '0, TAG_INT);
    send_request(A_SWAP, '0, TAG_INT);
    send_request(A_DUP, '0, TAG_INT);
    send_request(A_IAR, '0, TAG_INT);
    send_request(A_PUSH, {1'b1, 63'd0}, TAG_INT);
    send_request(A_PUSH, '1, TAG_INT);
    send_request(A_IDIV, '0, TAG_INT);
    send_request(A_PUSH, '1, TAG_BOOL);
    send_request(A_ISUB, '0, TAG_INT);
    send_request(A_PUSH, '0, TAG_INT);
    send_request(A_PUSH, 64'd5, TAG_INT);
    send_request(A_IMOD, '0, TAG_INT);
    send_request(A_PUSH, 64'h1FF, TAG_CHAR);
    send_request(A_C2B, '0, TAG_INT);
    send_request(A_PUSH, 64'd9, TAG_BYTE);
    send_request(A_BSHL, '0, TAG_INT);
    send_request(A_UNUSED, '1, TAG_CHAR);
    for (i = 0; i < 66; i++) send_request(A_PUSH, {$urandom, $urandom}, TAG_INT);
    send_request(A_DUP, '0, TAG_INT);
    for (i = 0; i < 66; i++) send_request(A_POP, '0, TAG_INT);
    for (i = 4; i <= A_LAST; i++) run_op(i[5:0]);

    // Random phases with different idle and stall rates
    for (phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
        default: begin send_idle_pct = 12; recv_stall_pct = 12; end
      endcase
      for (i = 0; i < 110; i++) begin
        case ($urandom_range(9))
          0: send_request(ACT_W'($urandom_range(63)), {$urandom, $urandom},
                          tag_e'($urandom_range(3)));
          1: send_request(ACT_W'($urandom_range(3)), rand_value(), tag_e'($urandom_range(3)));
          default: run_op(ACT_W'($urandom_range(4, A_LAST)));
        endcase
        if (sb.cnt > 40) repeat (8) send_request(A_POP, '0, TAG_INT);
      end
    end
    s_axis_tvalid_i <= 1'b0;

    i = 0;
    while (sb.pending.size() != 0 && i < 5000) begin
      @(posedge clk_i);
      i++;
    end
    repeat (100) @(posedge clk_i);
    $display("Sent %0d instructions, checked %0d results over four handshake phases.",
             sent, sb.checked);
    $display("Covered every action, underflow, type errors, divide by zero and overflow.");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("tagged_stack_alu regression: pass");
    else $display("tagged_stack_alu regression: fail");
    $finish;
  end

  initial begin
    #20ms;
    $display("tagged_stack_alu regression: fail");
    $finish;
  end

endmodule

### tagged_stack_alu.f
rtl/tsa_pkg.sv
rtl/tsa_mem.sv
rtl/tsa_alu.sv
rtl/tagged_stack_alu.sv
rtl/tsa_checker.sv
verif/tb_tagged_stack_alu.sv
